// ===== rtl/core/rdcr_pkg.sv =====
// ----------------------------------------------------------------------------
// rdcr_pkg
// Shared types, command codes and helpers for the drive command ramp block.
// ----------------------------------------------------------------------------
package rdcr_pkg;

   localparam int SPEED_W   = 7;
   localparam int TIMEOUT_W = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;

   // speed registers saturate here
   localparam logic [SPEED_W-1:0] SPEED_LIMIT = 7'd100;

   // truncating divide by 100 through a reciprocal
   localparam logic [12:0] DIV100_RECIP = 13'd5243;
   localparam int          DIV100_SHIFT = 19;

   // item modes
   localparam logic [1:0] MODE_CMD   = 2'd0;
   localparam logic [1:0] MODE_STICK = 2'd1;
   localparam logic [1:0] MODE_TICK  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BASE_SPEED = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_SPEED  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_STEP = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TURN_GAIN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_IDLE_LIMIT = 3'd4;

   // register reset values
   localparam logic [SPEED_W-1:0]   RST_BASE_SPEED = 7'd30;
   localparam logic [SPEED_W-1:0]   RST_MAX_SPEED  = 7'd100;
   localparam logic [SPEED_W-1:0]   RST_SPEED_STEP = 7'd10;
   localparam logic [SPEED_W-1:0]   RST_TURN_GAIN  = 7'd50;
   localparam logic [TIMEOUT_W-1:0] RST_IDLE_LIMIT = 32'd800;

   // command characters
   localparam logic [7:0] CMD_F = 8'h46;
   localparam logic [7:0] CMD_B = 8'h42;
   localparam logic [7:0] CMD_L = 8'h4C;
   localparam logic [7:0] CMD_R = 8'h52;
   localparam logic [7:0] CMD_U = 8'h55;
   localparam logic [7:0] CMD_D = 8'h44;
   localparam logic [7:0] CMD_W = 8'h57;
   localparam logic [7:0] CMD_X = 8'h58;
   localparam logic [7:0] CMD_Y = 8'h59;
   localparam logic [7:0] CMD_Z = 8'h5A;

   // debug codes
   localparam logic [3:0] DBG_STOP = 4'd0;
   localparam logic [3:0] DBG_F    = 4'd1;
   localparam logic [3:0] DBG_B    = 4'd2;
   localparam logic [3:0] DBG_L    = 4'd3;
   localparam logic [3:0] DBG_R    = 4'd4;
   localparam logic [3:0] DBG_U    = 4'd5;
   localparam logic [3:0] DBG_D    = 4'd6;
   localparam logic [3:0] DBG_W    = 4'd7;
   localparam logic [3:0] DBG_X    = 4'd8;
   localparam logic [3:0] DBG_Y    = 4'd9;
   localparam logic [3:0] DBG_Z    = 4'd10;

   typedef struct packed {
      logic [1:0]        mode;
      logic [7:0]        command_byte;
      logic signed [7:0] stick_straight;
      logic signed [7:0] stick_turn;
   } req_type;

   typedef struct packed {
      logic              drive_update;
      logic signed [7:0] straight_target;
      logic signed [7:0] turn_target;
      logic [3:0]        debug_code;
      logic              moving_flag;
      logic [7:0]        last_byte;
   } rsp_type;

   typedef struct packed {
      logic [SPEED_W-1:0]   base_speed;
      logic [SPEED_W-1:0]   max_speed;
      logic [SPEED_W-1:0]   speed_step;
      logic [SPEED_W-1:0]   turn_gain;
      logic [TIMEOUT_W-1:0] idle_limit;
   } cfg_type;

   typedef struct packed {
      logic [7:0]           prev_command;
      logic [TIMEOUT_W-1:0] idle_elapsed;
      logic                 motion_active;
      logic signed [7:0]    straight_acc;
      logic signed [7:0]    turn_acc;
      logic [3:0]           led_value;
   } state_type;

   // keep the low 7 bits, then saturate at 100
   function automatic logic [SPEED_W-1:0] sat_speed(input logic [CSR_DAT_W-1:0] v);
      logic [SPEED_W-1:0] low;
      low = v[SPEED_W-1:0];
      return (low > SPEED_LIMIT) ? SPEED_LIMIT : low;
   endfunction

   // floor(m / 100), exact for m below 43690
   function automatic logic [7:0] div100(input logic [14:0] m);
      logic [27:0] prod;
      prod = 28'(m) * 28'(DIV100_RECIP);
      return prod[DIV100_SHIFT +: 8];
   endfunction

endpackage

// ===== rtl/core/rdcr_csr.sv =====
// ----------------------------------------------------------------------------
// rdcr_csr
// Configuration registers with write-side saturation of the speed fields.
// ----------------------------------------------------------------------------
module rdcr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wen,
   input  logic [rdcr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rdcr_pkg::CSR_DAT_W-1:0]   csr_wdata,
   output rdcr_pkg::cfg_type                cfg
);

   rdcr_pkg::cfg_type cfg_ff;
   rdcr_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            rdcr_pkg::REG_BASE_SPEED: cfg_in.base_speed = rdcr_pkg::sat_speed(csr_wdata);
            rdcr_pkg::REG_MAX_SPEED:  cfg_in.max_speed  = rdcr_pkg::sat_speed(csr_wdata);
            rdcr_pkg::REG_SPEED_STEP: cfg_in.speed_step = rdcr_pkg::sat_speed(csr_wdata);
            rdcr_pkg::REG_TURN_GAIN:  cfg_in.turn_gain  = rdcr_pkg::sat_speed(csr_wdata);
            rdcr_pkg::REG_IDLE_LIMIT: cfg_in.idle_limit = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_speed <= rdcr_pkg::RST_BASE_SPEED;
         cfg_ff.max_speed  <= rdcr_pkg::RST_MAX_SPEED;
         cfg_ff.speed_step <= rdcr_pkg::RST_SPEED_STEP;
         cfg_ff.turn_gain  <= rdcr_pkg::RST_TURN_GAIN;
         cfg_ff.idle_limit <= rdcr_pkg::RST_IDLE_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/rdcr_step.sv =====
// ----------------------------------------------------------------------------
// rdcr_step
// Next-state and result logic for one item: ramp, gain scaling and timeout.
// ----------------------------------------------------------------------------
module rdcr_step (
   input  rdcr_pkg::cfg_type   cfg,
   input  rdcr_pkg::state_type cur,
   input  rdcr_pkg::req_type   item,
   output rdcr_pkg::state_type nxt,
   output rdcr_pkg::rsp_type   rsp
);

   logic [7:0]                        cmd;
   logic                              changed;
   logic                              up_dir;
   logic                              turn_axis;
   logic signed [9:0]                 base_s;
   logic signed [9:0]                 max_s;
   logic signed [9:0]                 step_s;
   logic signed [7:0]                 ramp_acc;
   logic signed [9:0]                 acc_ext;
   logic signed [9:0]                 ramp_sum;
   logic signed [9:0]                 ramp_diff;
   logic signed [9:0]                 ramp_wide;
   logic signed [7:0]                 ramp_res;
   logic signed [7:0]                 scale_in;
   logic signed [15:0]                scale_prod;
   logic [14:0]                       scale_mag;
   logic [7:0]                        scale_quo;
   logic signed [8:0]                 scale_res;
   logic signed [8:0]                 scale_neg;
   logic [3:0]                        led_code;
   logic [rdcr_pkg::TIMEOUT_W-1:0]    idle_inc;
   logic signed [9:0]                 stick_s_ext;
   logic signed [9:0]                 stick_t_ext;

   function automatic logic signed [7:0] clamp_mag(input logic signed [9:0] v,
                                                   input logic signed [9:0] lim);
      logic signed [9:0] r;
      if (v > lim)       r = lim;
      else if (v < -lim) r = -lim;
      else               r = v;
      return r[7:0];
   endfunction

   assign cmd       = item.command_byte;
   assign changed   = (cur.prev_command != cmd);
   assign up_dir    = cmd inside {rdcr_pkg::CMD_F, rdcr_pkg::CMD_R,
                                  rdcr_pkg::CMD_W, rdcr_pkg::CMD_Y};
   assign turn_axis = cmd inside {rdcr_pkg::CMD_L, rdcr_pkg::CMD_R};

   assign base_s = $signed({3'b000, cfg.base_speed});
   assign max_s  = $signed({3'b000, cfg.max_speed});
   assign step_s = $signed({3'b000, cfg.speed_step});

   // one ramp unit, shared by the straight and turn axes
   assign ramp_acc  = turn_axis ? cur.turn_acc : cur.straight_acc;
   assign acc_ext   = 10'(ramp_acc);
   assign ramp_sum  = acc_ext + step_s;
   assign ramp_diff = acc_ext - step_s;

   always_comb begin
      if (up_dir) begin
         if (changed || acc_ext <= 10'sd0) ramp_wide = base_s;
         else if (ramp_sum > max_s)        ramp_wide = max_s;
         else                              ramp_wide = ramp_sum;
      end else begin
         if (changed || acc_ext >= 10'sd0) ramp_wide = -base_s;
         else if (ramp_diff < -max_s)      ramp_wide = -max_s;
         else                              ramp_wide = ramp_diff;
      end
   end

   assign ramp_res = ramp_wide[7:0];

   // v * gain / 100, truncated toward zero
   assign scale_in   = (item.mode == rdcr_pkg::MODE_STICK) ? item.stick_turn : ramp_res;
   assign scale_prod = 16'(scale_in) * $signed({9'b0, cfg.turn_gain});
   assign scale_mag  = scale_prod[15] ? 15'(-scale_prod) : scale_prod[14:0];
   assign scale_quo  = rdcr_pkg::div100(scale_mag);
   assign scale_res  = scale_prod[15] ? -$signed({1'b0, scale_quo})
                                      : $signed({1'b0, scale_quo});
   assign scale_neg  = -scale_res;

   always_comb begin
      case (cmd)
         rdcr_pkg::CMD_F: led_code = rdcr_pkg::DBG_F;
         rdcr_pkg::CMD_B: led_code = rdcr_pkg::DBG_B;
         rdcr_pkg::CMD_L: led_code = rdcr_pkg::DBG_L;
         rdcr_pkg::CMD_R: led_code = rdcr_pkg::DBG_R;
         rdcr_pkg::CMD_U: led_code = rdcr_pkg::DBG_U;
         rdcr_pkg::CMD_D: led_code = rdcr_pkg::DBG_D;
         rdcr_pkg::CMD_W: led_code = rdcr_pkg::DBG_W;
         rdcr_pkg::CMD_X: led_code = rdcr_pkg::DBG_X;
         rdcr_pkg::CMD_Y: led_code = rdcr_pkg::DBG_Y;
         rdcr_pkg::CMD_Z: led_code = rdcr_pkg::DBG_Z;
         default:         led_code = cmd[3:0];
      endcase
   end

   assign idle_inc    = (&cur.idle_elapsed) ? cur.idle_elapsed : cur.idle_elapsed + 1'b1;
   assign stick_s_ext = 10'(item.stick_straight);
   assign stick_t_ext = 10'(scale_res);

   always_comb begin
      nxt                 = cur;
      rsp.drive_update    = 1'b0;
      rsp.straight_target = 8'sd0;
      rsp.turn_target     = 8'sd0;
      case (item.mode)
         rdcr_pkg::MODE_CMD: begin
            nxt.idle_elapsed = '0;
            nxt.prev_command = cmd;
            nxt.led_value    = led_code;
            rsp.drive_update = 1'b1;
            case (cmd)
               rdcr_pkg::CMD_F, rdcr_pkg::CMD_B: begin
                  nxt.straight_acc = ramp_res;
                  nxt.turn_acc     = 8'sd0;
               end
               rdcr_pkg::CMD_L, rdcr_pkg::CMD_R: begin
                  nxt.turn_acc     = ramp_res;
                  nxt.straight_acc = 8'sd0;
               end
               rdcr_pkg::CMD_U: begin
                  nxt.straight_acc = $signed({1'b0, cfg.max_speed});
                  nxt.turn_acc     = 8'sd0;
               end
               rdcr_pkg::CMD_W, rdcr_pkg::CMD_Z: begin
                  nxt.straight_acc = ramp_res;
                  nxt.turn_acc     = scale_neg[7:0];
               end
               rdcr_pkg::CMD_X, rdcr_pkg::CMD_Y: begin
                  nxt.straight_acc = ramp_res;
                  nxt.turn_acc     = scale_res[7:0];
               end
               default: begin
                  // stop byte and unknown bytes only note the byte
                  rsp.drive_update = 1'b0;
               end
            endcase
            if (rsp.drive_update) begin
               nxt.motion_active   = 1'b1;
               rsp.straight_target = nxt.straight_acc;
               rsp.turn_target     = nxt.turn_acc;
            end
         end
         rdcr_pkg::MODE_STICK: begin
            nxt.idle_elapsed    = '0;
            nxt.motion_active   = (item.stick_straight != 8'sd0) ||
                                  (item.stick_turn != 8'sd0);
            rsp.drive_update    = 1'b1;
            rsp.straight_target = clamp_mag(stick_s_ext, max_s);
            rsp.turn_target     = clamp_mag(stick_t_ext, max_s);
         end
         rdcr_pkg::MODE_TICK: begin
            nxt.idle_elapsed = idle_inc;
            if (cur.motion_active && idle_inc >= cfg.idle_limit) begin
               nxt.straight_acc  = 8'sd0;
               nxt.turn_acc      = 8'sd0;
               nxt.motion_active = 1'b0;
               nxt.led_value     = rdcr_pkg::DBG_STOP;
               rsp.drive_update  = 1'b1;
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
      rsp.debug_code  = nxt.led_value;
      rsp.moving_flag = nxt.motion_active;
      rsp.last_byte   = nxt.prev_command;
   end

endmodule

// ===== rtl/core/remote_drive_command_ramp.sv =====
// ----------------------------------------------------------------------------
// remote_drive_command_ramp
// Drive command ramp: command bytes, joystick pairs and ticks to target speeds.
// ----------------------------------------------------------------------------
// Every transfer in gives exactly one transfer out, through the input register
// and then the result register. One item per cycle is sustained while the
// output is not stalled; the state loop (ramp, gain scale by a reciprocal
// divide by 100, idle counter) is combinational between the input register
// and the state registers. Configuration registers are written through the
// csr port; speed values keep their low 7 bits, then saturate at 100.
module remote_drive_command_ramp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  rdcr_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output rdcr_pkg::rsp_type                rsp_data,
   input  logic                             csr_wen,
   input  logic [rdcr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rdcr_pkg::CSR_DAT_W-1:0]   csr_wdata
);

   rdcr_pkg::cfg_type   cfg;
   rdcr_pkg::state_type state_ff;
   rdcr_pkg::state_type state_in;
   rdcr_pkg::req_type   in_data_ff;
   rdcr_pkg::req_type   in_data_in;
   rdcr_pkg::rsp_type   rsp_data_ff;
   rdcr_pkg::rsp_type   rsp_data_in;
   rdcr_pkg::state_type step_state;
   rdcr_pkg::rsp_type   step_rsp;
   logic                in_valid_ff;
   logic                in_valid_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                out_free;
   logic                advance;

   rdcr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rdcr_step u_step (
      .cfg  (cfg),
      .cur  (state_ff),
      .item (in_data_ff),
      .nxt  (step_state),
      .rsp  (step_rsp)
   );

   // result register can take a new value when empty or being drained
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      state_in     = state_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         if (req_valid) begin
            in_data_in = req_data;
         end
      end
      if (out_free) begin
         rsp_valid_in = in_valid_ff;
      end
      if (advance) begin
         rsp_data_in = step_rsp;
         state_in    = step_state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/rdcr_checker.sv =====
// ----------------------------------------------------------------------------
// rdcr_checker
// Port-level checks of the drive command ramp, bound to the top level.
// ----------------------------------------------------------------------------
module rdcr_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rdcr_pkg::rsp_type rsp_data
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // no result right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // targets are zero when nothing is issued
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.drive_update |->
         rsp_data.straight_target == 8'sd0 && rsp_data.turn_target == 8'sd0)
      else $error("targets without drive update");

   // issued targets stay within the percent range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.drive_update |->
         rsp_data.straight_target <= 8'sd100 && rsp_data.straight_target >= -8'sd100 &&
         rsp_data.turn_target <= 8'sd100 && rsp_data.turn_target >= -8'sd100)
      else $error("target out of range");

   // an update while not moving must be a full stop
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.drive_update && !rsp_data.moving_flag |->
         rsp_data.straight_target == 8'sd0 && rsp_data.turn_target == 8'sd0)
      else $error("nonzero target while stopped");

endmodule

bind remote_drive_command_ramp rdcr_checker u_rdcr_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== verif/remote_drive_command_ramp_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// remote_drive_command_ramp_tb
// Self-checking bench for the drive command ramp. A scoreboard predicts every
// result from the command, joystick and tick transfers it has sent. Directed
// tests cover ramps, diagonals, stray bytes, joystick clamping, timeouts, the
// spare mode and a base speed above the limit. Random phases follow, under
// several register settings and, in most of them, with idling on both channels.
// ----------------------------------------------------------------------------
module remote_drive_command_ramp_tb;
   import rdcr_pkg::*;

   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int RANDOM_BLOCKS = 6;
   localparam int BLOCK_ITEMS   = 120;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   // scoreboard copy of the registers and the drive state
   int                   cfg_base;
   int                   cfg_max;
   int                   cfg_step;
   int                   cfg_gain;
   logic [31:0]          cfg_timeout;
   logic [7:0]           m_prev_cmd;
   logic [31:0]          m_idle;
   bit                   m_moving;
   int                   m_straight;
   int                   m_turn;
   logic [3:0]           m_led;

   rsp_type              pending_drive[$];
   int                   errors = 0;
   int                   req_idle_pct = 0;
   int                   rsp_idle_pct = 0;

   remote_drive_command_ramp dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   // ---------------------------------------------------------------- model

   function automatic int clip_pct(input logic [31:0] v);
      return (v[6:0] > 7'd100) ? 100 : int'(v[6:0]);
   endfunction

   function automatic int clamp_lim(input int v, input int lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic int gain_scale(input int v);
      return (v * cfg_gain) / 100;
   endfunction

   function automatic int ramp_fwd(input int acc, input bit changed);
      if (changed || acc <= 0) return cfg_base;
      acc += cfg_step;
      return (acc > cfg_max) ? cfg_max : acc;
   endfunction

   function automatic int ramp_rev(input int acc, input bit changed);
      if (changed || acc >= 0) return -cfg_base;
      acc -= cfg_step;
      return (acc < -cfg_max) ? -cfg_max : acc;
   endfunction

   function automatic void reset_model();
      cfg_base    = int'(RST_BASE_SPEED);
      cfg_max     = int'(RST_MAX_SPEED);
      cfg_step    = int'(RST_SPEED_STEP);
      cfg_gain    = int'(RST_TURN_GAIN);
      cfg_timeout = RST_IDLE_LIMIT;
      m_prev_cmd  = '0;
      m_idle      = '0;
      m_moving    = 1'b0;
      m_straight  = 0;
      m_turn      = 0;
      m_led       = DBG_STOP;
   endfunction

   function automatic rsp_type predict_drive(input req_type it);
      rsp_type    r;
      logic [7:0] c;
      bit         changed;
      bit         drive;
      int         ss;
      int         st;
      r = '0;
      case (it.mode)
         MODE_CMD: begin
            c = it.command_byte;
            changed = (m_prev_cmd != c);
            drive = 1'b1;
            m_idle = '0;
            m_prev_cmd = c;
            case (c)
               CMD_F:   m_led = DBG_F;
               CMD_B:   m_led = DBG_B;
               CMD_L:   m_led = DBG_L;
               CMD_R:   m_led = DBG_R;
               CMD_U:   m_led = DBG_U;
               CMD_D:   m_led = DBG_D;
               CMD_W:   m_led = DBG_W;
               CMD_X:   m_led = DBG_X;
               CMD_Y:   m_led = DBG_Y;
               CMD_Z:   m_led = DBG_Z;
               default: m_led = c[3:0];
            endcase
            case (c)
               CMD_F: begin
                  m_straight = ramp_fwd(m_straight, changed);
                  m_turn = 0;
               end
               CMD_B: begin
                  m_straight = ramp_rev(m_straight, changed);
                  m_turn = 0;
               end
               CMD_L: begin
                  m_turn = ramp_rev(m_turn, changed);
                  m_straight = 0;
               end
               CMD_R: begin
                  m_turn = ramp_fwd(m_turn, changed);
                  m_straight = 0;
               end
               CMD_U: begin
                  m_straight = cfg_max;
                  m_turn = 0;
               end
               CMD_W: begin
                  m_straight = ramp_fwd(m_straight, changed);
                  m_turn = -gain_scale(m_straight);
               end
               CMD_X: begin
                  m_straight = ramp_rev(m_straight, changed);
                  m_turn = gain_scale(m_straight);
               end
               CMD_Y: begin
                  m_straight = ramp_fwd(m_straight, changed);
                  m_turn = gain_scale(m_straight);
               end
               CMD_Z: begin
                  m_straight = ramp_rev(m_straight, changed);
                  m_turn = -gain_scale(m_straight);
               end
               default: drive = 1'b0;
            endcase
            if (drive) begin
               m_moving = 1'b1;
               r.drive_update = 1'b1;
               r.straight_target = m_straight[7:0];
               r.turn_target = m_turn[7:0];
            end
         end
         MODE_STICK: begin
            ss = $signed(it.stick_straight);
            st = $signed(it.stick_turn);
            m_idle = '0;
            m_moving = (ss != 0) || (st != 0);
            r.straight_target = 8'(clamp_lim(ss, cfg_max));
            r.turn_target = 8'(clamp_lim(gain_scale(st), cfg_max));
            r.drive_update = 1'b1;
         end
         MODE_TICK: begin
            if (m_idle != 32'hFFFF_FFFF) m_idle++;
            if (m_moving && m_idle >= cfg_timeout) begin
               m_straight = 0;
               m_turn = 0;
               m_moving = 1'b0;
               m_led = DBG_STOP;
               r.drive_update = 1'b1;
            end
         end
         default: ;
      endcase
      r.debug_code = m_led;
      r.moving_flag = m_moving;
      r.last_byte = m_prev_cmd;
      return r;
   endfunction

   // ---------------------------------------------------------------- checker

   task automatic report(input string fld, input logic [31:0] want, input logic [31:0] got);
      errors++;
      $display("%0t ns: %s expected %0h, got %0h", $time, fld, want, got);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_drive.size() == 0) begin
            errors++;
            $display("%0t ns: result expected none, got %p", $time, rsp_data);
         end else begin
            want = pending_drive.pop_front();
            if (rsp_data.drive_update !== want.drive_update)
               report("drive_update", want.drive_update, rsp_data.drive_update);
            if (rsp_data.straight_target !== want.straight_target)
               report("straight_target", want.straight_target, rsp_data.straight_target);
            if (rsp_data.turn_target !== want.turn_target)
               report("turn_target", want.turn_target, rsp_data.turn_target);
            if (rsp_data.debug_code !== want.debug_code)
               report("debug_code", want.debug_code, rsp_data.debug_code);
            if (rsp_data.moving_flag !== want.moving_flag)
               report("moving_flag", want.moving_flag, rsp_data.moving_flag);
            if (rsp_data.last_byte !== want.last_byte)
               report("last_byte", want.last_byte, rsp_data.last_byte);
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   // called and returns at a falling edge
   task automatic send_req(input req_type it);
      int gap;
      gap = 0;
      while ($urandom_range(99) < req_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      pending_drive.push_back(predict_drive(it));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_drive.size() != 0);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         REG_BASE_SPEED: cfg_base = clip_pct(value);
         REG_MAX_SPEED:  cfg_max = clip_pct(value);
         REG_SPEED_STEP: cfg_step = clip_pct(value);
         REG_TURN_GAIN:  cfg_gain = clip_pct(value);
         REG_IDLE_LIMIT: cfg_timeout = value;
         default: ;
      endcase
      @(negedge clock);
      csr_wen <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_all(input logic [31:0] base, input logic [31:0] max_v,
                            input logic [31:0] step, input logic [31:0] gain,
                            input logic [31:0] tmo);
      write_csr(REG_BASE_SPEED, base);
      write_csr(REG_MAX_SPEED, max_v);
      write_csr(REG_SPEED_STEP, step);
      write_csr(REG_TURN_GAIN, gain);
      write_csr(REG_IDLE_LIMIT, tmo);
   endtask

   // unused fields carry noise so the block has to ignore them
   function automatic req_type cmd_item(input logic [7:0] c);
      req_type it;
      it.mode = MODE_CMD;
      it.command_byte = c;
      it.stick_straight = 8'($urandom);
      it.stick_turn = 8'($urandom);
      return it;
   endfunction

   function automatic req_type stick_item(input logic [7:0] s, input logic [7:0] t);
      req_type it;
      it.mode = MODE_STICK;
      it.command_byte = 8'($urandom);
      it.stick_straight = s;
      it.stick_turn = t;
      return it;
   endfunction

   function automatic req_type tick_item();
      req_type it;
      it = 26'($urandom);
      it.mode = MODE_TICK;
      return it;
   endfunction

   function automatic req_type spare_item();
      req_type it;
      it = 26'($urandom);
      it.mode = MODE_SPARE;
      return it;
   endfunction

   function automatic logic [7:0] rand_stick();
      case ($urandom_range(5))
         0:       return 8'h00;
         1:       return 8'h7F;
         2:       return 8'h80;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] rand_drive_cmd();
      case ($urandom_range(8))
         0:       return CMD_F;
         1:       return CMD_B;
         2:       return CMD_L;
         3:       return CMD_R;
         4:       return CMD_U;
         5:       return CMD_W;
         6:       return CMD_X;
         7:       return CMD_Y;
         default: return CMD_Z;
      endcase
   endfunction

   function automatic logic [31:0] rand_pct_reg();
      case ($urandom_range(4))
         0:       return 32'd0;
         1:       return 32'd100;
         2:       return $urandom;
         default: return $urandom_range(100);
      endcase
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_command_ramp();
      repeat (3) send_req(cmd_item(CMD_F));
      repeat (2) send_req(cmd_item(CMD_B));
      send_req(cmd_item(CMD_L));
      repeat (2) send_req(cmd_item(CMD_R));
      send_req(cmd_item(CMD_U));
   endtask

   task automatic test_diagonals();
      repeat (2) send_req(cmd_item(CMD_W));
      send_req(cmd_item(CMD_X));
      send_req(cmd_item(CMD_Y));
      send_req(cmd_item(CMD_Z));
   endtask

   task automatic test_other_bytes();
      send_req(cmd_item(CMD_D));
      send_req(cmd_item(8'h00));
      send_req(cmd_item(8'hFF));
   endtask

   task automatic test_joystick();
      send_req(stick_item(8'h7F, 8'h80));
      send_req(stick_item(8'h00, 8'h00));
      send_req(stick_item(8'h80, 8'h7F));
   endtask

   task automatic test_spare_mode();
      send_req(spare_item());
   endtask

   task automatic test_tick_timeout();
      wait_drained();
      write_csr(REG_IDLE_LIMIT, 32'd2);
      send_req(cmd_item(CMD_F));
      repeat (3) send_req(tick_item());
      wait_drained();
      write_csr(REG_IDLE_LIMIT, 32'd0);
      send_req(stick_item(8'h05, 8'h00));
      send_req(tick_item());
   endtask

   task automatic test_base_above_max();
      wait_drained();
      // raw all-ones saturates to 100, well above the limit of 20
      write_all(32'hFFFF_FFFF, 32'd20, 32'd0, 32'(RST_TURN_GAIN), RST_IDLE_LIMIT);
      repeat (2) send_req(cmd_item(CMD_B));
   endtask

   task automatic test_random();
      int count;
      int n;
      for (int b = 0; b < RANDOM_BLOCKS; b++) begin
         wait_drained();
         case (b)
            0:       write_all(32'd0, 32'd100, 32'd100, 32'd100, 32'd0);
            1:       write_all(32'd100, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
            default: write_all(rand_pct_reg(), rand_pct_reg(), rand_pct_reg(),
                               rand_pct_reg(), $urandom_range(24));
         endcase
         // spare indexes must not disturb anything
         write_csr(CSR_IDX_W'($urandom_range(5, 7)), $urandom);
         case (b / 2)
            0: begin
               req_idle_pct = 14;
               rsp_idle_pct = 58;
            end
            1: begin
               req_idle_pct = 58;
               rsp_idle_pct = 14;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         count = 0;
         while (count < BLOCK_ITEMS) begin
            case ($urandom_range(19))
               0, 1, 2, 3, 4, 5, 6, 7, 8: begin
                  // runs of random drive commands, which ramp the speed where a command repeats
                  n = $urandom_range(1, 6);
                  repeat (n) send_req(cmd_item(rand_drive_cmd()));
                  count += n;
               end
               9, 10: begin
                  send_req(cmd_item(($urandom_range(1) == 0) ? CMD_D : 8'($urandom)));
                  count++;
               end
               11, 12, 13: begin
                  send_req(stick_item(rand_stick(), rand_stick()));
                  count++;
               end
               14, 15, 16, 17, 18: begin
                  if (cfg_timeout <= 24) n = $urandom_range(1, cfg_timeout + 3);
                  else n = $urandom_range(1, 8);
                  repeat (n) send_req(tick_item());
                  count += n;
               end
               default: begin
                  send_req(spare_item());
                  count++;
               end
            endcase
            if ($urandom_range(49) == 0) wait_drained();
         end
      end
   endtask

   initial begin
      reset_model();
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      req_idle_pct = 14;
      rsp_idle_pct = 58;
      test_command_ramp();
      test_diagonals();
      test_other_bytes();
      test_joystick();
      test_spare_mode();
      test_tick_timeout();
      test_base_above_max();
      test_random();
      wait_drained();
      repeat (8) @(negedge clock);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/rdcr_pkg.sv
rtl/core/rdcr_csr.sv
rtl/core/rdcr_step.sv
rtl/core/remote_drive_command_ramp.sv
rtl/core/rdcr_checker.sv
verif/remote_drive_command_ramp_tb.sv
